@@ rtl/matrix_inverse_4x4_top_defines.svh @@
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX_INVERSE_4X4_TOP_DEFINES_SVH
`define MATRIX_INVERSE_4X4_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define MI4_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mi4 property failed");
// Check that a condition never holds outside reset.
`define MI4_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("mi4 forbidden condition seen");
`else
`define MI4_ASSERT(label, clk, rst, prop)
`define MI4_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ rtl/mi4_pkg.sv @@
package mi4_pkg;

  localparam int MATRIX_ORDER = 4;
  localparam int ELEMENTS     = MATRIX_ORDER * MATRIX_ORDER;

  localparam logic [3:0] LAST_INDEX = 4'd15;

  // Configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DET_ONLY  = 1'b1;

  // Datapath operations
  localparam logic [2:0] OP_MOV = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_NEG = 3'd3;
  localparam logic [2:0] OP_MUL = 3'd4;

  // Operand sources
  localparam logic [2:0] SRC_EA  = 3'd0;
  localparam logic [2:0] SRC_EB  = 3'd1;
  localparam logic [2:0] SRC_P   = 3'd2;
  localparam logic [2:0] SRC_M2  = 3'd3;
  localparam logic [2:0] SRC_A3  = 3'd4;
  localparam logic [2:0] SRC_DET = 3'd5;
  localparam logic [2:0] SRC_COF = 3'd6;
  localparam logic [2:0] SRC_INV = 3'd7;

  // Result destinations
  localparam logic [2:0] DST_M2  = 3'd0;
  localparam logic [2:0] DST_P   = 3'd1;
  localparam logic [2:0] DST_A3  = 3'd2;
  localparam logic [2:0] DST_DET = 3'd3;
  localparam logic [2:0] DST_COF = 3'd4;
  localparam logic [2:0] DST_OUT = 3'd5;

  // Kinds of emitted result
  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_DET  = 2'd1;
  localparam logic [1:0] KIND_BUF  = 2'd2;

  typedef struct packed {
    logic       exec;
    logic [2:0] op;
    logic [2:0] xsel;
    logic [2:0] ysel;
    logic [2:0] dst;
    logic [3:0] addr_a;
    logic [3:0] addr_b;
    logic [3:0] out_addr;
    logic       div_start;
    logic       emit;
    logic [1:0] emit_kind;
    logic [3:0] emit_idx;
    logic       emit_last;
  } ctl_t;

  typedef struct packed {
    logic singular;
    logic det_only;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic        clip;
    logic [31:0] val;
  } sat_t;

  // Clip a wide signed value to 32 bits and flag the clip
  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = 32'h8000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

  // k-th of the three indexes left after removing skip
  function automatic logic [1:0] others(input logic [1:0] skip, input logic [1:0] k);
    return (k < skip) ? k : k + 2'd1;
  endfunction

endpackage

@@ rtl/mi4_recip.sv @@
module mi4_recip
  import mi4_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] det,
  output logic [31:0] inv,
  output logic        inv_clip,
  output logic        done
);

  localparam int NW = (2 * FRACTION_BITS + 1 > 31) ? 2 * FRACTION_BITS + 2 : 32;
  localparam int CW = $clog2(NW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [NW-1:0] num;
  logic [NW-1:0] quo;
  logic [31:0]   rem;
  logic [31:0]   mag;
  logic          neg;

  logic [31:0]   mag_in;
  logic [32:0]   rem_sh;
  logic          ge;
  logic [NW-1:0] quo_next;
  logic [31:0]   fin_val;
  logic          fin_clip;

  assign mag_in = det[31] ? (~det + 32'd1) : det;

  // One quotient bit per cycle, restoring
  always_comb begin
    rem_sh   = {rem, num[NW-1]};
    ge       = (rem_sh >= {1'b0, mag});
    quo_next = {quo[NW-2:0], ge};
    if (neg) begin
      if (quo_next > NW'(64'h8000_0000)) begin
        fin_clip = 1'b1;
        fin_val  = 32'h8000_0000;
      end else begin
        fin_clip = 1'b0;
        fin_val  = ~quo_next[31:0] + 32'd1;
      end
    end else begin
      if (quo_next > NW'(64'h7fff_ffff)) begin
        fin_clip = 1'b1;
        fin_val  = 32'h7fff_ffff;
      end else begin
        fin_clip = 1'b0;
        fin_val  = quo_next[31:0];
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(NW);
      end else if (running) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Advance the shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      mag <= mag_in;
      neg <= det[31];
      num <= (NW'(1) << (2 * FRACTION_BITS)) + NW'(mag_in[31:1]);
      quo <= '0;
      rem <= '0;
    end else if (running) begin
      num <= num << 1;
      quo <= quo_next;
      rem <= ge ? 32'(rem_sh - {1'b0, mag}) : rem_sh[31:0];
      if (cnt == CW'(1)) begin
        inv      <= fin_val;
        inv_clip <= fin_clip;
      end
    end
  end

endmodule

@@ rtl/mi4_ctrl.sv @@
module mi4_ctrl
  import mi4_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DET    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_COF    = 3'd5;
  localparam logic [2:0] S_CDRAIN = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] outer, outer_next;
  logic [1:0] inner, inner_next;
  logic [1:0] term, term_next;
  logic [2:0] sub, sub_next;
  logic [3:0] k, k_next;
  logic       zero_mode, zero_mode_next;

  logic [1:0] skip_row, skip_col;
  logic [1:0] r0, r1, r2, c0, c1, c2;
  logic [1:0] ra, rb, rl;
  logic       loop_end;

  assign busy = (state != S_IDLE);

  // Pick the minor's rows and columns
  always_comb begin
    if (state == S_DET) begin
      skip_row = outer;
      skip_col = 2'd0;
    end else begin
      skip_row = inner;
      skip_col = outer;
    end
    r0 = others(skip_row, 2'd0);
    r1 = others(skip_row, 2'd1);
    r2 = others(skip_row, 2'd2);
    c0 = others(skip_col, 2'd0);
    c1 = others(skip_col, 2'd1);
    c2 = others(skip_col, 2'd2);
    rl = (term == 2'd0) ? r0 : ((term == 2'd1) ? r1 : r2);
    ra = (term == 2'd0) ? r1 : r0;
    rb = (term == 2'd2) ? r1 : r2;
  end

  // Issue one datapath command per cycle
  always_comb begin
    ctl = '0;
    if (state == S_DET || state == S_COF) begin
      ctl.exec = 1'b1;
      if (term != 2'd3) begin
        unique case (sub)
          3'd0: begin
            ctl.op = OP_MUL; ctl.xsel = SRC_EA; ctl.ysel = SRC_EB; ctl.dst = DST_M2;
            ctl.addr_a = {ra, c1};
            ctl.addr_b = {rb, c2};
          end
          3'd1: begin
            ctl.op = OP_MUL; ctl.xsel = SRC_EA; ctl.ysel = SRC_EB; ctl.dst = DST_P;
            ctl.addr_a = {ra, c2};
            ctl.addr_b = {rb, c1};
          end
          3'd2: begin
            ctl.op = OP_SUB; ctl.xsel = SRC_M2; ctl.ysel = SRC_P; ctl.dst = DST_M2;
          end
          3'd3: begin
            ctl.op = OP_MUL; ctl.xsel = SRC_EA; ctl.ysel = SRC_M2; ctl.dst = DST_P;
            ctl.addr_a = {rl, c0};
          end
          default: begin
            ctl.dst = DST_A3;
            priority case (term)
              2'd0: begin
                ctl.op = OP_MOV; ctl.xsel = SRC_P;
              end
              2'd1: begin
                ctl.op = OP_SUB; ctl.xsel = SRC_A3; ctl.ysel = SRC_P;
              end
              default: begin
                ctl.op = OP_ADD; ctl.xsel = SRC_A3; ctl.ysel = SRC_P;
              end
            endcase
          end
        endcase
      end else if (state == S_DET) begin
        if (sub == 3'd0) begin
          ctl.op = OP_MUL; ctl.xsel = SRC_EA; ctl.ysel = SRC_A3; ctl.dst = DST_P;
          ctl.addr_a = {outer, 2'd0};
        end else begin
          ctl.dst  = DST_DET;
          ctl.ysel = SRC_P;
          if (outer == 2'd0) begin
            ctl.op = OP_MOV; ctl.xsel = SRC_P;
          end else if (outer[0]) begin
            ctl.op = OP_SUB; ctl.xsel = SRC_DET;
          end else begin
            ctl.op = OP_ADD; ctl.xsel = SRC_DET;
          end
        end
      end else begin
        if (sub == 3'd0) begin
          ctl.op   = (outer[0] ^ inner[0]) ? OP_NEG : OP_MOV;
          ctl.xsel = SRC_A3;
          ctl.dst  = DST_COF;
        end else begin
          ctl.op = OP_MUL; ctl.xsel = SRC_COF; ctl.ysel = SRC_INV; ctl.dst = DST_OUT;
          ctl.out_addr = {outer, inner};
        end
      end
    end
    if (state == S_DECIDE) begin
      if (sts.det_only) begin
        ctl.emit      = 1'b1;
        ctl.emit_kind = KIND_DET;
        ctl.emit_last = 1'b1;
      end else if (!sts.singular) begin
        ctl.div_start = 1'b1;
      end
    end
    if (state == S_EMIT) begin
      ctl.emit      = 1'b1;
      ctl.emit_kind = zero_mode ? KIND_ZERO : KIND_BUF;
      ctl.emit_idx  = k;
      ctl.emit_last = (k == LAST_INDEX);
    end
  end

  // Sequence the run
  always_comb begin
    state_next     = state;
    outer_next     = outer;
    inner_next     = inner;
    term_next      = term;
    sub_next       = sub;
    k_next         = k;
    zero_mode_next = zero_mode;
    loop_end       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (go) begin
          state_next = S_DET;
          outer_next = 2'd0;
          inner_next = 2'd0;
          term_next  = 2'd0;
          sub_next   = 3'd0;
        end
      end
      S_DET, S_COF: begin
        if (term == 2'd3) begin
          if (sub == 3'd0) begin
            sub_next = 3'd1;
          end else begin
            sub_next  = 3'd0;
            term_next = 2'd0;
            loop_end  = 1'b1;
          end
        end else if (sub == 3'd4) begin
          sub_next  = 3'd0;
          term_next = term + 2'd1;
        end else begin
          sub_next = sub + 3'd1;
        end
        if (loop_end) begin
          if (state == S_DET) begin
            outer_next = outer + 2'd1;
            if (outer == 2'd3) begin
              state_next = S_DRAIN;
            end
          end else begin
            inner_next = inner + 2'd1;
            if (inner == 2'd3) begin
              outer_next = outer + 2'd1;
              if (outer == 2'd3) begin
                state_next = S_CDRAIN;
              end
            end
          end
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        k_next = 4'd0;
        if (sts.det_only) begin
          state_next = S_IDLE;
        end else if (sts.singular) begin
          zero_mode_next = 1'b1;
          state_next     = S_EMIT;
        end else begin
          zero_mode_next = 1'b0;
          state_next     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_COF;
          outer_next = 2'd0;
          inner_next = 2'd0;
          term_next  = 2'd0;
          sub_next   = 3'd0;
        end
      end
      S_CDRAIN: begin
        k_next     = 4'd0;
        state_next = S_EMIT;
      end
      default: begin
        k_next = k + 4'd1;
        if (k == LAST_INDEX) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      outer     <= 2'd0;
      inner     <= 2'd0;
      term      <= 2'd0;
      sub       <= 3'd0;
      k         <= 4'd0;
      zero_mode <= 1'b0;
    end else begin
      state     <= state_next;
      outer     <= outer_next;
      inner     <= inner_next;
      term      <= term_next;
      sub       <= sub_next;
      k         <= k_next;
      zero_mode <= zero_mode_next;
    end
  end

endmodule

@@ rtl/mi4_datapath.sv @@
`include "matrix_inverse_4x4_top_defines.svh"
module mi4_datapath
  import mi4_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [31:0] element_value,
  input  logic [3:0]  element_index,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  ctl_t        ctl,
  output sts_t        sts,
  output logic        result_valid,
  output logic [31:0] result_value,
  output logic [3:0]  result_index,
  output logic [31:0] determinant_value,
  output logic        singular,
  output logic        saturated,
  output logic        last_result
);

  logic [31:0] mat_mem [ELEMENTS];
  logic [31:0] out_mem [ELEMENTS];

  ctl_t        cq;
  logic [31:0] ea, eb;
  logic [31:0] p_r, m2_r, a3_r, det_r, cof_r;
  logic [16:0] thr;
  logic        det_only;
  logic        clip;

  logic [31:0] inv;
  logic        inv_clip;
  logic        recip_done;

  logic signed [31:0] x, y;
  logic signed [63:0] xw, yw, prod, shf;
  sat_t               res;
  logic [32:0]        mag;

  mi4_recip #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .det      (det_r),
    .inv      (inv),
    .inv_clip (inv_clip),
    .done     (recip_done)
  );

  // Matrix store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (load) begin
      mat_mem[element_index] <= element_value;
    end
    ea <= mat_mem[ctl.addr_a];
    eb <= mat_mem[ctl.addr_b];
  end

  // Align the command with its read data
  always_ff @(posedge clk) begin
    if (rst) begin
      cq <= '0;
    end else begin
      cq <= ctl;
    end
  end

  // Select operands
  always_comb begin
    unique case (cq.xsel)
      SRC_EA:  x = ea;
      SRC_EB:  x = eb;
      SRC_P:   x = p_r;
      SRC_M2:  x = m2_r;
      SRC_A3:  x = a3_r;
      SRC_DET: x = det_r;
      SRC_COF: x = cof_r;
      default: x = inv;
    endcase
    unique case (cq.ysel)
      SRC_EA:  y = ea;
      SRC_EB:  y = eb;
      SRC_P:   y = p_r;
      SRC_M2:  y = m2_r;
      SRC_A3:  y = a3_r;
      SRC_DET: y = det_r;
      SRC_COF: y = cof_r;
      default: y = inv;
    endcase
  end

  // Shared arithmetic unit: rounded product, sum, difference or negation, all saturated; or move
  always_comb begin
    xw   = {{32{x[31]}}, x};
    yw   = {{32{y[31]}}, y};
    prod = xw * yw;
    shf  = (prod + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    unique case (cq.op)
      OP_ADD:  res = sat64(xw + yw);
      OP_SUB:  res = sat64(xw - yw);
      OP_NEG:  res = sat64(-xw);
      OP_MUL:  res = sat64(shf);
      default: res = '{clip: 1'b0, val: x};
    endcase
  end

  // Write back the result
  always_ff @(posedge clk) begin
    if (cq.exec) begin
      unique case (cq.dst)
        DST_M2:  m2_r  <= res.val;
        DST_P:   p_r   <= res.val;
        DST_A3:  a3_r  <= res.val;
        DST_DET: det_r <= res.val;
        DST_COF: cof_r <= res.val;
        default: out_mem[cq.out_addr] <= res.val;
      endcase
    end
  end

  // Configuration registers and clip flag
  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= 17'd1;
      det_only <= 1'b0;
      clip     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: thr      <= cfg_data;
          default:       det_only <= cfg_data[0];
        endcase
      end
      if (load && element_index == LAST_INDEX) begin
        clip <= 1'b0;
      end else if ((cq.exec && res.clip) || (recip_done && inv_clip)) begin
        clip <= 1'b1;
      end
    end
  end

  assign mag = det_r[31] ? (~{1'b1, det_r} + 33'd1) : {1'b0, det_r};

  assign sts.singular = (mag <= {16'd0, thr});
  assign sts.det_only = det_only;
  assign sts.div_done = recip_done;

  // Present one result per strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      result_index <= ctl.emit_idx;
      last_result  <= ctl.emit_last;
      unique case (ctl.emit_kind)
        KIND_BUF: result_value <= out_mem[ctl.emit_idx];
        KIND_DET: result_value <= det_r;
        default:  result_value <= 32'd0;
      endcase
    end
  end

  assign determinant_value = det_r;
  assign singular          = sts.singular;
  assign saturated         = clip;

  `MI4_ASSERT(a_burst_unbroken, clk, rst, (result_valid && !last_result) |=> result_valid)
  `MI4_ASSERT(a_load_quiet, clk, rst, load |=> !result_valid)
  `MI4_ASSERT(a_recip_multicycle, clk, rst, ctl.div_start |=> !recip_done)

endmodule

@@ rtl/matrix_inverse_4x4_top.sv @@
// 4x4 fixed-point matrix inverse by cofactor expansion.
// Input: element_value/element_index are transferred at a clock edge with
// start high and busy low. Indexes 0..14 only store the element (busy stays
// low). Index 15 stores the element and starts a run; busy then stays high
// until the last result command has been issued.
// Configuration: cfg_index/cfg_data are transferred when cfg_valid and
// cfg_ready are high (ready while not busy). Index 0 is the singular
// threshold (Q format), index 1 selects determinant-only output.
// Results: one per cycle while result_valid is high, with last_result on the
// final one. The receiver cannot stall; results are never held.
// Sequence: the determinant takes 4 x 17 commands on one shared
// multiply/add unit; determinant-only output follows it. A full inverse
// adds a 2F+2 bit (at least 32) bit-serial reciprocal and 16 x 17
// cofactor commands, then 16 results. Unless determinant-only is set, a
// singular matrix gives 16 zero results right after the determinant.
// Reset clears control and configuration (threshold 1, full inverse); the
// matrix store is undefined until written.
module matrix_inverse_4x4_top
  import mi4_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] element_value,
  input  logic [3:0]  element_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  output logic        result_valid,
  output logic [31:0] result_value,
  output logic [3:0]  result_index,
  output logic [31:0] determinant_value,
  output logic        singular,
  output logic        saturated,
  output logic        last_result
);

  ctl_t ctl;
  sts_t sts;
  logic load;
  logic go;

  assign load      = start && !busy;
  assign go        = load && (element_index == LAST_INDEX);
  assign cfg_ready = !busy;

  mi4_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy)
  );

  mi4_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .load              (load),
    .element_value     (element_value),
    .element_index     (element_index),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .ctl               (ctl),
    .sts               (sts),
    .result_valid      (result_valid),
    .result_value      (result_value),
    .result_index      (result_index),
    .determinant_value (determinant_value),
    .singular          (singular),
    .saturated         (saturated),
    .last_result       (last_result)
  );

endmodule
